@@ rtl/core/lfsrlc_pkg.sv @@
// ----------------------------------------------------------------------------
// lfsrlc_pkg
// Shared types and constants for the binary linear complexity finder.
// ----------------------------------------------------------------------------
package lfsrlc_pkg;

    localparam int POLY_W  = 64;
    localparam int LEN_W   = 7;
    localparam int GAP_MAX = 127;

    // engine state carried from one bit to the next
    typedef struct packed {
        logic [POLY_W-1:0] history_bits;
        logic [POLY_W-1:0] current_poly;
        logic [POLY_W-1:0] previous_poly;
        logic [LEN_W-1:0]  linear_length;
        logic [LEN_W-1:0]  shift_gap;
        logic [LEN_W-1:0]  bit_count;
        logic              overflowed;
    } state_t;

    // one result request
    typedef struct packed {
        logic              discrepancy;
        logic [LEN_W-1:0]  complexity;
        logic [POLY_W-1:0] connection_poly;
        logic              overflow;
    } result_t;

    localparam state_t STATE_RESET = '{
        history_bits:  '0,
        current_poly:  POLY_W'(1),
        previous_poly: POLY_W'(1),
        linear_length: '0,
        shift_gap:     LEN_W'(1),
        bit_count:     '0,
        overflowed:    1'b0
    };

endpackage

@@ rtl/core/lfsrlc_update.sv @@
// ----------------------------------------------------------------------------
// lfsrlc_update
// One Berlekamp-Massey step over GF(2): discrepancy, polynomial and length
// update for a single sequence bit.
// ----------------------------------------------------------------------------
module lfsrlc_update
    import lfsrlc_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  state_t  cur_state,
    input  logic    start_new,
    input  logic    seq_bit,
    output state_t  next_state,
    output result_t result
);

    localparam logic [POLY_W-1:0] PMASK =
        POLY_W'((65'(1) << MAX_LEN) - 65'(1));
    localparam logic [LEN_W-1:0] MAX_LEN_V = LEN_W'(MAX_LEN);

    state_t            st;
    logic [POLY_W-1:0] len_mask;
    logic [POLY_W-1:0] shifted_prev;
    logic              disc;
    logic              grow;

    // restart clears everything before this bit is used
    assign st = start_new ? STATE_RESET : cur_state;

    // taps below the current length take part in the prediction
    always_comb begin
        for (int i = 0; i < POLY_W; i++) begin
            len_mask[i] = (LEN_W'(i) < st.linear_length);
        end
    end

    assign disc = seq_bit ^ (^((st.current_poly >> 1) & st.history_bits & len_mask));

    // a gap of the full length or more pushes B(D) out entirely
    assign shifted_prev = (st.shift_gap < MAX_LEN_V) ?
                          (st.previous_poly << st.shift_gap) : '0;

    assign grow = ({1'b0, st.linear_length, 1'b0} <= {2'b00, st.bit_count});

    always_comb begin
        next_state = st;
        result.discrepancy     = 1'b0;
        result.complexity      = st.linear_length;
        result.connection_poly = st.current_poly;
        result.overflow        = 1'b1;
        if (st.bit_count >= MAX_LEN_V) begin
            // sequence too long: flag it, leave the engine untouched
            next_state.overflowed = 1'b1;
        end else begin
            if (disc) begin
                next_state.current_poly = (st.current_poly ^ shifted_prev) & PMASK;
                if (grow) begin
                    next_state.linear_length = st.bit_count + LEN_W'(1) - st.linear_length;
                    next_state.previous_poly = st.current_poly;
                    next_state.shift_gap     = LEN_W'(1);
                end else if (st.shift_gap < LEN_W'(GAP_MAX)) begin
                    next_state.shift_gap = st.shift_gap + LEN_W'(1);
                end
            end else if (st.shift_gap < LEN_W'(GAP_MAX)) begin
                next_state.shift_gap = st.shift_gap + LEN_W'(1);
            end
            next_state.history_bits = {st.history_bits[POLY_W-2:0], seq_bit};
            next_state.bit_count    = st.bit_count + LEN_W'(1);
            result.discrepancy      = disc;
            result.complexity       = next_state.linear_length;
            result.connection_poly  = next_state.current_poly;
            result.overflow         = 1'b0;
        end
    end

endmodule

@@ rtl/core/lfsr_linear_complexity_finder_top.sv @@
// ----------------------------------------------------------------------------
// lfsr_linear_complexity_finder_top
// Streaming binary Berlekamp-Massey engine reporting linear complexity and
// connection polynomial after every sequence bit.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one sequence bit per request, s_tuser raises start of a new
//   sequence (state is cleared before that bit is used).
//   m_ channel: one result per input request, in order.
//   cfg_wr_en/cfg_wr_data: invert_input, write only while the block is idle.
// Pipeline: an accepted bit is registered in the input register, then the
//   update runs from the input register into the result register once that
//   register is free or being drained.
// Throughput: one bit per cycle while m_tready stays high; the state loop
//   (masked 64-bit parity, shifted XOR of B(D), length compare) is combinational.
// Reset: synchronous, active low; clears both stages, the engine state
//   (C(D)=B(D)=1, L=0) and invert_input.
// Stall: while m_tready is low the result holds and one more bit may wait
//   in the input register; s_tready then drops until the result is taken.
// Past MAX_LEN bits a result carries overflow in m_tuser and the state holds.
// ----------------------------------------------------------------------------
module lfsr_linear_complexity_finder_top
    import lfsrlc_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,  // invert_input
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [0] seq_bit, [7:1] zero
    input  logic        s_tuser,      // [0] start_new
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,      // [0] discrepancy, [7:1] complexity,
                                      // [71:8] connection_poly
    output logic        m_tuser       // [0] overflow
);

    logic    invert_reg;
    logic    in_valid_reg;
    logic    in_bit_reg;
    logic    in_start_reg;
    logic    out_valid_reg;
    result_t out_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    logic    advance;

    // input stage moves on when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            invert_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_bit_reg   <= s_tdata[0];
            in_start_reg <= s_tuser;
        end
    end

    lfsrlc_update #(
        .MAX_LEN (MAX_LEN)
    ) u_update (
        .cur_state  (state_reg),
        .start_new  (in_start_reg),
        .seq_bit    (in_bit_reg ^ invert_reg),
        .next_state (state_next),
        .result     (result_next)
    );

    // engine state advances once per bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.connection_poly, out_reg.complexity, out_reg.discrepancy};
    assign m_tuser  = out_reg.overflow;

    // checks
    a_poly_bit0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[8])
        else $error("connection polynomial lost its constant term");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:1] <= 7'd64))
        else $error("complexity out of range");

    a_ovf_no_disc: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> !m_tdata[0])
        else $error("overflowed result reports a discrepancy");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with an empty result register");

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Checks the streaming binary Berlekamp-Massey engine. Sequence bits are sent
// one request at a time, and a local update model predicts discrepancy,
// linear complexity, connection polynomial and overflow for each one. Runs
// directed cases first, then LFSR-generated, random and broken sequences
// under both input polarities, with random stalls on both streams until the full-rate phase.
// ----------------------------------------------------------------------------
module tb
    import lfsrlc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int              MAX_LEN   = 64;
    localparam logic [63:0]     POLY_MASK = (64'd1 << MAX_LEN) - 64'd1;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'd0;   // [0] seq_bit, [7:1] zero
    logic        s_tuser     = 1'b0;   // [0] start_new
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [71:0] m_tdata;              // [0] discrepancy, [7:1] complexity,
                                       // [71:8] connection_poly
    logic        m_tuser;              // [0] overflow

    // engine state and polarity as the model sees them
    state_t      bm_state  = STATE_RESET;
    logic        bm_invert = 1'b0;
    result_t     bm_result_queue[$];
    int          error_count = 0;
    bit          idle_on     = 1'b1;

    lfsr_linear_complexity_finder_top #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // one Berlekamp-Massey update for one sequence bit
    function automatic result_t berlekamp_step(input logic bit_in, input logic start);
        logic        s;
        logic        d;
        logic [63:0] saved;
        logic [63:0] len_mask;
        result_t     r;
        s = bit_in ^ bm_invert;
        if (start) begin
            bm_state = STATE_RESET;
        end
        // past the length limit nothing moves
        if (int'(bm_state.bit_count) >= MAX_LEN) begin
            bm_state.overflowed = 1'b1;
            r.discrepancy       = 1'b0;
            r.complexity        = bm_state.linear_length;
            r.connection_poly   = bm_state.current_poly;
            r.overflow          = 1'b1;
            return r;
        end
        // shift by 64 gives zero, so the mask is all ones at full length
        len_mask = (64'd1 << bm_state.linear_length) - 64'd1;
        d = s ^ (^((bm_state.current_poly >> 1) & bm_state.history_bits & len_mask));
        if (d) begin
            saved = bm_state.current_poly;
            if (int'(bm_state.shift_gap) < MAX_LEN) begin
                bm_state.current_poly = (bm_state.current_poly
                    ^ (bm_state.previous_poly << bm_state.shift_gap)) & POLY_MASK;
            end
            if (2 * int'(bm_state.linear_length) <= int'(bm_state.bit_count)) begin
                bm_state.linear_length = bm_state.bit_count + 7'd1 - bm_state.linear_length;
                bm_state.previous_poly = saved;
                bm_state.shift_gap     = 7'd1;
            end else if (int'(bm_state.shift_gap) < GAP_MAX) begin
                bm_state.shift_gap++;
            end
        end else if (int'(bm_state.shift_gap) < GAP_MAX) begin
            bm_state.shift_gap++;
        end
        bm_state.history_bits = (bm_state.history_bits << 1) | 64'(s);
        bm_state.bit_count++;
        r.discrepancy     = d;
        r.complexity      = bm_state.linear_length;
        r.connection_poly = bm_state.current_poly;
        r.overflow        = 1'b0;
        return r;
    endfunction

    // send one sequence bit, with an occasional gap before it
    task automatic send_bit(input logic bit_in, input logic start);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, bit_in};
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bm_result_queue.push_back(berlekamp_step(bit_in, start));
    endtask

    // wait for all results, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (bm_result_queue.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // invert_input write while idle
    task automatic write_invert(input logic value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        bm_invert    = value;
    endtask

    // mix of LFSR output, random bits and broken sequences
    task automatic run_random_phase(input int n_items);
        int          sent;
        int          kind;
        int          seq_len;
        int          degree;
        logic [63:0] taps;
        logic [63:0] lfsr_hist;
        logic [63:0] fill;
        logic        nb;
        logic        st;
        sent = 0;
        while (sent < n_items) begin
            kind    = $urandom_range(0, 9);
            seq_len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 72)
                                                  : $urandom_range(1, 64);
            degree  = $urandom_range(1, 40);
            taps    = ({$urandom, $urandom} & ((64'd1 << degree) - 64'd1))
                      | (64'd1 << (degree - 1));
            fill    = {$urandom, $urandom};
            lfsr_hist = '0;
            for (int n = 0; n < seq_len; n++) begin
                if (kind < 6) begin
                    nb = (n < degree) ? fill[n] : ^(taps & lfsr_hist);
                end else begin
                    nb = 1'($urandom_range(0, 1));
                end
                // noise may continue the previous sequence or restart anywhere
                st = (kind < 8) ? (n == 0) : ($urandom_range(0, 7) == 0);
                lfsr_hist = (lfsr_hist << 1) | 64'(nb);
                send_bit(nb, st);
                sent++;
            end
        end
    endtask

    task automatic test_directed_basics();
        send_bit(1'b1, 1'b1);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        send_bit(1'b0, 1'b0);
        // restart in the middle of a sequence
        send_bit(1'b0, 1'b1);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        send_bit(1'b1, 1'b0);
    endtask

    task automatic test_invert_input();
        write_invert(1'b1);
        send_bit(1'b0, 1'b1);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        send_bit(1'b0, 1'b0);
        write_invert(1'b0);
    endtask

    task automatic test_overflow_and_large_shift();
        // a long zero run brings shift_gap up to the full length before the first one
        for (int n = 0; n < MAX_LEN + 3; n++) begin
            send_bit(logic'(n == MAX_LEN - 1), logic'(n == 0));
        end
        // restart clears the overflow
        send_bit(1'b1, 1'b1);
        send_bit(1'b0, 1'b0);
        // same again with inverted polarity
        write_invert(1'b1);
        for (int n = 0; n < MAX_LEN + 3; n++) begin
            send_bit(logic'(n != MAX_LEN - 1), logic'(n == 0));
        end
        send_bit(1'b0, 1'b1);
        write_invert(1'b0);
    endtask

    task automatic test_random_with_idling();
        for (int phase = 0; phase < 4; phase++) begin
            write_invert(logic'(phase % 2));
            run_random_phase(200);
        end
    endtask

    task automatic test_random_full_rate();
        write_invert(1'b0);
        idle_on = 1'b0;
        run_random_phase(250);
    endtask

    // result stream back-pressure
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // compare each result request with the oldest prediction
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (bm_result_queue.size() == 0) begin
                $error("result with no bit outstanding: tdata %h tuser %b", m_tdata, m_tuser);
                error_count++;
            end else begin
                want = bm_result_queue.pop_front();
                if (m_tdata[0] !== want.discrepancy) begin
                    $error("discrepancy: expected %0d, got %0d", want.discrepancy, m_tdata[0]);
                    error_count++;
                end
                if (m_tdata[7:1] !== want.complexity) begin
                    $error("complexity: expected %0d, got %0d", want.complexity, m_tdata[7:1]);
                    error_count++;
                end
                if (m_tdata[71:8] !== want.connection_poly) begin
                    $error("connection_poly: expected %h, got %h",
                           want.connection_poly, m_tdata[71:8]);
                    error_count++;
                end
                if (m_tuser !== want.overflow) begin
                    $error("overflow: expected %0d, got %0d", want.overflow, m_tuser);
                    error_count++;
                end
            end
        end
    end

    // test sequence
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_basics();
        test_invert_input();
        test_overflow_and_large_shift();
        test_random_with_idling();
        test_random_full_rate();
        drain();
        repeat (4) @(posedge aclk);
        if (error_count == 0) begin
            $display("lfsr_linear_complexity_finder_top test passed");
        end else begin
            $display("lfsr_linear_complexity_finder_top test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4ms;
        $display("lfsr_linear_complexity_finder_top test failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/lfsrlc_pkg.sv
rtl/core/lfsrlc_update.sv
rtl/core/lfsr_linear_complexity_finder_top.sv
sim/tb.sv
